// ===== rtl/core/c2s_pkg.sv =====
// Shared constants, types and CORDIC helpers of the Cartesian to spherical converter.
package c2s_pkg;

  // Field and arithmetic widths.
  localparam int COORD_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STAGES   = 16;
  localparam int ACC_FRAC        = 30;
  localparam int AZ_SHIFT        = 60 - COORD_BITS;
  localparam int RHO_POST        = 28;
  localparam int RND_SHIFT       = ACC_FRAC - ANGLE_FRAC_BITS;

  // Square root pipeline: one root bit per stage on a 64-bit radicand.
  localparam int SQ_STEPS = 32;
  localparam int RAD_W    = 2 * SQ_STEPS;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int REM_W    = SQ_STEPS + 2;
  localparam int SQ_LANES = 3;
  localparam int LANE_R   = 0;
  localparam int LANE_RHO = 1;
  localparam int LANE_D   = 2;

  // CORDIC datapath widths.
  localparam int CW = 64;
  localparam int ZW = 35;
  localparam int CO_LANES = 2;
  localparam int LANE_AZ  = 0;
  localparam int LANE_POL = 1;

  localparam logic signed [ZW-1:0] PI_ACC = 35'sd3373259426;

  // Arctangent of 2^-i in radians scaled by 2^30, floored.
  localparam logic [29:0] ATAN_TAB [0:31] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,
    30'd63,        30'd31,        30'd15,        30'd7,
    30'd3,         30'd1,         30'd0,         30'd0
  };

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zacc_t;

  // State of one vectoring CORDIC lane.
  typedef struct packed {
    cval_t a;
    cval_t b;
    zacc_t z;
    logic  zero;
  } cstate_t;

  // Folds a vector with negative a into the right half plane.
  function automatic cstate_t cordic_init(cval_t a, cval_t b);
    cstate_t s;
    s.zero = (a == '0) && (b == '0);
    if (a < 0) begin
      s.z = (b >= 0) ? PI_ACC : -PI_ACC;
      s.a = -a;
      s.b = -b;
    end else begin
      s.z = '0;
      s.a = a;
      s.b = b;
    end
    return s;
  endfunction

  // One micro-rotation toward b = 0.
  function automatic cstate_t cordic_step(cstate_t s, int i);
    cstate_t n;
    cval_t   da;
    cval_t   db;
    zacc_t   t;
    da = s.b >>> i;
    db = s.a >>> i;
    t  = zacc_t'({5'b0, ATAN_TAB[i]});
    n.zero = s.zero;
    if (!s.b[CW-1]) begin
      n.a = s.a + da;
      n.b = s.b - db;
      n.z = s.z + t;
    end else begin
      n.a = s.a - da;
      n.b = s.b + db;
      n.z = s.z - t;
    end
    return n;
  endfunction

  // Rounds the accumulator to the output scale, ties away from zero.
  function automatic logic [15:0] round_angle(cstate_t s);
    logic [ZW-1:0] mag;
    logic [ZW-1:0] r;
    mag = s.z[ZW-1] ? ZW'(-s.z) : ZW'(s.z);
    r   = (mag + (ZW'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
    if (s.z[ZW-1]) begin
      r = ZW'(0) - r;
    end
    return s.zero ? 16'd0 : r[15:0];
  endfunction

endpackage

// ===== rtl/core/cartesian_to_spherical_converter.sv =====
// Converts a point to spherical coordinates and measures its distance to a reference point.
// One word enters per clock while the output is not stalled. The squares and then their sums
// are registered, the pipelined square roots run one root bit per stage, the entry fold
// brings the vectors into the right half plane, the two CORDIC lanes for azimuth and polar
// angle run side by side, and the output register takes both angles rounded. A stall of the
// output freezes the whole pipeline, and in_stall_o is raised only while a finished word
// waits on a stalled output. Angles are radians scaled by 8192; the azimuth is 0 when x and
// y are zero and the polar angle is 0 at the origin.
module cartesian_to_spherical_converter import c2s_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] px_i,
  input  logic signed [15:0] py_i,
  input  logic signed [15:0] pz_i,
  input  logic signed [15:0] ref_x_i,
  input  logic signed [15:0] ref_y_i,
  input  logic signed [15:0] ref_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        radius_o,
  output logic [15:0]        cyl_radius_o,
  output logic signed [15:0] azimuth_o,
  output logic [14:0]        polar_angle_o,
  output logic [16:0]        distance_o
);

  // Global advance: the pipeline moves whenever the output register can take a word.
  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: squares of the coordinates and of the differences.
  logic               v1_q;
  logic signed [15:0] x1_q, y1_q, z1_q;
  logic [31:0]        sx_q, sy_q, sz_q;
  logic [32:0]        dx2_q, dy2_q, dz2_q;
  logic signed [16:0] dx_d, dy_d, dz_d;
  logic signed [31:0] px2_d, py2_d, pz2_d;
  logic signed [33:0] dx2_d, dy2_d, dz2_d;

  always_comb begin
    dx_d  = {px_i[15], px_i} - {ref_x_i[15], ref_x_i};
    dy_d  = {py_i[15], py_i} - {ref_y_i[15], ref_y_i};
    dz_d  = {pz_i[15], pz_i} - {ref_z_i[15], ref_z_i};
    px2_d = px_i * px_i;
    py2_d = py_i * py_i;
    pz2_d = pz_i * pz_i;
    dx2_d = dx_d * dx_d;
    dy2_d = dy_d * dy_d;
    dz2_d = dz_d * dz_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= px_i;
      y1_q  <= py_i;
      z1_q  <= pz_i;
      sx_q  <= px2_d;
      sy_q  <= py2_d;
      sz_q  <= pz2_d;
      dx2_q <= dx2_d[32:0];
      dy2_q <= dy2_d[32:0];
      dz2_q <= dz2_d[32:0];
    end
  end

  // Stage 2: sums of squares.
  logic               v2_q;
  logic signed [15:0] x2_q, y2_q, z2_q;
  logic [31:0]        qxy_q, qr_q;
  logic [33:0]        qd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      z2_q  <= z1_q;
      qxy_q <= sx_q + sy_q;
      qr_q  <= sx_q + sy_q + sz_q;
      qd_q  <= {1'b0, dx2_q} + {1'b0, dy2_q} + {1'b0, dz2_q};
    end
  end

  // Square root pipeline: three lanes, one root bit per stage.
  logic               sr_v_q    [SQ_STEPS];
  logic signed [15:0] sr_x_q    [SQ_STEPS];
  logic signed [15:0] sr_y_q    [SQ_STEPS];
  logic signed [15:0] sr_z_q    [SQ_STEPS];
  logic [RAD_W-1:0]   sr_rad_q  [SQ_STEPS][SQ_LANES];
  logic [REM_W-1:0]   sr_rem_q  [SQ_STEPS][SQ_LANES];
  logic [ROOT_W-1:0]  sr_root_q [SQ_STEPS][SQ_LANES];
  logic [RAD_W-1:0]   sr_rad_d  [SQ_STEPS][SQ_LANES];
  logic [REM_W-1:0]   sr_rem_d  [SQ_STEPS][SQ_LANES];
  logic [ROOT_W-1:0]  sr_root_d [SQ_STEPS][SQ_LANES];

  always_comb begin
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  sh;
    logic [REM_W-1:0]  trial;
    for (int k = 0; k < SQ_STEPS; k++) begin
      for (int l = 0; l < SQ_LANES; l++) begin
        if (k == 0) begin
          rem_in  = '0;
          root_in = '0;
          case (l)
            LANE_R:   rad_in = {32'd0, qr_q};
            LANE_RHO: rad_in = {qxy_q, 32'd0};
            default:  rad_in = {30'd0, qd_q};
          endcase
        end else begin
          rad_in  = sr_rad_q[k-1][l];
          rem_in  = sr_rem_q[k-1][l];
          root_in = sr_root_q[k-1][l];
        end
        sh    = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        trial = {root_in, 2'b01};
        sr_rad_d[k][l] = rad_in << 2;
        if (sh >= trial) begin
          sr_rem_d[k][l]  = sh - trial;
          sr_root_d[k][l] = {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          sr_rem_d[k][l]  = sh;
          sr_root_d[k][l] = {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        sr_x_q[k] <= (k == 0) ? x2_q : sr_x_q[(k == 0) ? 0 : k - 1];
        sr_y_q[k] <= (k == 0) ? y2_q : sr_y_q[(k == 0) ? 0 : k - 1];
        sr_z_q[k] <= (k == 0) ? z2_q : sr_z_q[(k == 0) ? 0 : k - 1];
        for (int l = 0; l < SQ_LANES; l++) begin
          sr_rad_q[k][l]  <= sr_rad_d[k][l];
          sr_rem_q[k][l]  <= sr_rem_d[k][l];
          sr_root_q[k][l] <= sr_root_d[k][l];
        end
      end
    end
  end

  // CORDIC pipeline: entry fold then one micro-rotation per stage, two lanes.
  logic              cv_q   [CORDIC_STAGES+1];
  cstate_t           cs_q   [CORDIC_STAGES+1][CO_LANES];
  logic [15:0]       crad_q [CORDIC_STAGES+1];
  logic [15:0]       ccyl_q [CORDIC_STAGES+1];
  logic [16:0]       cdst_q [CORDIC_STAGES+1];
  logic [ROOT_W-1:0] rho_root;
  cval_t             az_a, az_b, pol_a, pol_b;

  always_comb begin
    rho_root = sr_root_q[SQ_STEPS-1][LANE_RHO];
    az_a     = cval_t'(sr_x_q[SQ_STEPS-1]) <<< AZ_SHIFT;
    az_b     = cval_t'(sr_y_q[SQ_STEPS-1]) <<< AZ_SHIFT;
    pol_a    = cval_t'(sr_z_q[SQ_STEPS-1]) <<< AZ_SHIFT;
    pol_b    = cval_t'({4'd0, rho_root, 28'd0});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_q[0][LANE_AZ]  <= cordic_init(az_a, az_b);
      cs_q[0][LANE_POL] <= cordic_init(pol_a, pol_b);
      crad_q[0] <= sr_root_q[SQ_STEPS-1][LANE_R][15:0];
      ccyl_q[0] <= rho_root[31:16];
      cdst_q[0] <= sr_root_q[SQ_STEPS-1][LANE_D][16:0];
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        crad_q[i+1] <= crad_q[i];
        ccyl_q[i+1] <= ccyl_q[i];
        cdst_q[i+1] <= cdst_q[i];
        for (int l = 0; l < CO_LANES; l++) begin
          cs_q[i+1][l] <= cordic_step(cs_q[i][l], i);
        end
      end
    end
  end

  // Output register with rounding of both angles.
  logic [15:0] az_rnd, pol_rnd;
  logic [15:0] rad_q, cyl_q;
  logic [15:0] az_q;
  logic [14:0] pol_q;
  logic [16:0] dst_q;

  assign az_rnd  = round_angle(cs_q[CORDIC_STAGES][LANE_AZ]);
  assign pol_rnd = round_angle(cs_q[CORDIC_STAGES][LANE_POL]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= crad_q[CORDIC_STAGES];
      cyl_q <= ccyl_q[CORDIC_STAGES];
      dst_q <= cdst_q[CORDIC_STAGES];
      az_q  <= az_rnd;
      pol_q <= pol_rnd[14:0];
    end
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sr_v_q[k] <= 1'b0;
      end
      for (int i = 0; i <= CORDIC_STAGES; i++) begin
        cv_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sr_v_q[k] <= (k == 0) ? v2_q : sr_v_q[(k == 0) ? 0 : k - 1];
      end
      cv_q[0] <= sr_v_q[SQ_STEPS-1];
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        cv_q[i+1] <= cv_q[i];
      end
      out_vld_q <= cv_q[CORDIC_STAGES];
    end
  end

  assign out_valid_o   = out_vld_q;
  assign radius_o      = rad_q;
  assign cyl_radius_o  = cyl_q;
  assign azimuth_o     = az_q;
  assign polar_angle_o = pol_q;
  assign distance_o    = dst_q;

endmodule

// ===== rtl/core/c2s_checker.sv =====
// Port-level checker of the Cartesian to spherical converter and its bind.
module c2s_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [15:0]        radius_o,
  input logic [15:0]        cyl_radius_o,
  input logic signed [15:0] azimuth_o,
  input logic [14:0]        polar_angle_o,
  input logic [16:0]        distance_o
);

  // A stalled output word stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word does not change.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(radius_o) && $stable(cyl_radius_o) &&
      $stable(azimuth_o) && $stable(polar_angle_o) && $stable(distance_o))
    else $error("output word changed while stalled");

  // The input is held off only while a finished word waits on a stalled output.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // The cylindrical radius never exceeds the radius.
  a_cyl_le_r: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cyl_radius_o <= radius_o)
    else $error("cylindrical radius above radius");

  // At the origin both angles are zero.
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && radius_o == 16'd0 |-> polar_angle_o == 15'd0 && azimuth_o == 16'sd0)
    else $error("nonzero angle at the origin");

endmodule

bind cartesian_to_spherical_converter c2s_checker u_c2s_checker (.*);
